// File: rtl/rmq_pkg.sv
// Package: sizes, types and per-queue state layout of the relaxed multi-queue
package rmq_pkg;

    localparam int QUEUES      = 8;
    localparam int RING_DEPTH  = 64;
    localparam int MAX_CHOICES = 2;

    localparam int QUEUE_W = $clog2(QUEUES);
    localparam int RING_W  = $clog2(RING_DEPTH);
    localparam int FILL_W  = RING_W + 1;
    localparam int ADDR_W  = QUEUE_W + RING_W;
    localparam int VALUE_W = 32;
    localparam int STAMP_W = 32;
    localparam int PICK_W  = 3;
    localparam int CFG_W   = 2;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef struct packed {
        logic [RING_W-1:0]  head;
        logic [FILL_W-1:0]  fill;
        logic [STAMP_W-1:0] last_enq;
        logic [STAMP_W-1:0] last_deq;
    } t_meta;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        t_entry            wdata;
    } t_ring_req;

endpackage

// File: rtl/rmq_if.sv
// Interfaces: operation channel and result channel with valid/ready handshake
interface rmq_op_if import rmq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               func;
    logic [VALUE_W-1:0] item_value;
    logic [PICK_W-1:0]  pick_first;
    logic [PICK_W-1:0]  pick_second;

    modport source (output valid, func, item_value, pick_first, pick_second, input ready);
    modport sink   (input valid, func, item_value, pick_first, pick_second, output ready);
endinterface

interface rmq_res_if import rmq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] out_value;
    logic               was_empty;
    logic               was_full;
    logic [PICK_W-1:0]  chosen_queue;

    modport source (output valid, out_value, was_empty, was_full, chosen_queue, input ready);
    modport sink   (input valid, out_value, was_empty, was_full, chosen_queue, output ready);
endinterface

// File: rtl/rmq_ring.sv
// Ring storage: value and stamp of every slot of every queue, one write and one read port
module rmq_ring import rmq_pkg::*; (
    input  logic      i_clk,
    input  t_ring_req i_req,
    output t_entry    o_rdata
);

    t_entry r_mem [QUEUES*RING_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/relaxed_multi_queue.sv
// Top level: relaxed multi-queue, a bank of FIFO rings chosen by one or two candidates
//
// Each item is an enqueue or a dequeue on one of QUEUES rings of RING_DEPTH slots.
// An enqueue, or a dequeue that finds its queue empty, passes through the states
// ST_IDLE and ST_EXEC; a dequeue that returns an item passes through ST_FIN as well.
// ST_EXEC and ST_FIN wait while the result register is full. The per-queue state memory
// (head, fill and the last enqueue and dequeue stamps, read at both candidates) has a
// registered read, and so, for a dequeue, has the ring memory holding the stored value
// and its stamp. One item is in work at a time; the result register lets the next item
// enter while a result waits. Results leave in order, one per item.
module relaxed_multi_queue import rmq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    rmq_op_if.sink           i_in,
    rmq_res_if.source        o_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0]   r_choice;
    logic [STAMP_W-1:0] r_stamp_ctr;

    logic               r_func;
    logic [VALUE_W-1:0] r_value;
    logic [QUEUE_W-1:0] r_qa;
    logic [QUEUE_W-1:0] r_qb;
    logic               r_two;
    logic [QUEUE_W-1:0] r_q;
    t_meta              r_mq;

    t_meta              r_meta_mem [QUEUES];
    logic [QUEUES-1:0]  r_meta_vld;
    t_meta              r_meta_a;
    t_meta              r_meta_b;
    logic               r_vld_a;
    logic               r_vld_b;

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_empty;
    logic               r_out_full;
    logic [PICK_W-1:0]  r_out_queue;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic [QUEUE_W-1:0] in_qa;
    logic [QUEUE_W-1:0] in_qb;
    t_meta              meta_a;
    t_meta              meta_b;
    logic               sel_b;
    logic [QUEUE_W-1:0] q;
    t_meta              mq;
    logic               is_full;
    logic               is_empty;
    logic [RING_W-1:0]  slot;
    logic               meta_we;
    logic [QUEUE_W-1:0] meta_waddr;
    t_meta              meta_wdata;
    t_ring_req          ring_req;
    t_entry             ring_rdata;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign in_qa    = i_in.pick_first[QUEUE_W-1:0];
    assign in_qb    = i_in.pick_second[QUEUE_W-1:0];
    assign out_load = out_free &&
                      (((r_state == ST_EXEC) && !((r_func == FUNC_DEQ) && !is_empty)) ||
                       (r_state == ST_FIN));

    always_comb begin
        meta_a = r_vld_a ? r_meta_a : '0;
        meta_b = r_vld_b ? r_meta_b : '0;
        if (r_func == FUNC_ENQ) begin
            sel_b = r_two && (meta_b.last_enq < meta_a.last_enq);
        end else begin
            sel_b = r_two && ((meta_a.fill == '0) ||
                    ((meta_b.fill != '0) && (meta_b.last_deq < meta_a.last_deq)));
        end
        q        = sel_b ? r_qb : r_qa;
        mq       = sel_b ? meta_b : meta_a;
        is_full  = mq.fill >= FILL_W'(RING_DEPTH);
        is_empty = mq.fill == '0;
        slot     = mq.head + mq.fill[RING_W-1:0];
    end

    always_comb begin
        ring_req.we    = (r_state == ST_EXEC) && out_free && (r_func == FUNC_ENQ) && !is_full;
        ring_req.re    = (r_state == ST_EXEC) && out_free && (r_func == FUNC_DEQ) && !is_empty;
        ring_req.addr  = {q, (r_func == FUNC_ENQ) ? slot : mq.head};
        ring_req.wdata = '{value: r_value, stamp: r_stamp_ctr};
    end

    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = q;
        meta_wdata = mq;
        if (r_state == ST_EXEC) begin
            meta_we             = ring_req.we;
            meta_wdata.fill     = mq.fill + FILL_W'(1);
            meta_wdata.last_enq = r_stamp_ctr;
        end else if (r_state == ST_FIN) begin
            meta_we             = out_free;
            meta_waddr          = r_q;
            meta_wdata          = r_mq;
            meta_wdata.head     = r_mq.head + RING_W'(1);
            meta_wdata.fill     = r_mq.fill - FILL_W'(1);
            meta_wdata.last_deq = ring_rdata.stamp;
        end
    end

    rmq_ring u_ring (
        .i_clk   (i_clk),
        .i_req   (ring_req),
        .o_rdata (ring_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_waddr] <= meta_wdata;
        end
        if (accept) begin
            r_meta_a <= r_meta_mem[in_qa];
            r_meta_b <= r_meta_mem[in_qb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_choice    <= CFG_W'(1);
            r_stamp_ctr <= '0;
            r_meta_vld  <= '0;
            r_vld_a     <= 1'b0;
            r_vld_b     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_choice <= i_cfg_wdata;
            end
            if (meta_we) begin
                r_meta_vld[meta_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_func      <= i_in.func;
                        r_value     <= i_in.item_value;
                        r_qa        <= in_qa;
                        r_qb        <= in_qb;
                        r_two       <= (MAX_CHOICES >= 2) && r_choice[1];
                        r_vld_a     <= r_meta_vld[in_qa];
                        r_vld_b     <= r_meta_vld[in_qb];
                        r_stamp_ctr <= r_stamp_ctr + STAMP_W'(1);
                        r_state     <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        if (r_func == FUNC_DEQ && !is_empty) begin
                            r_q     <= q;
                            r_mq    <= mq;
                            r_state <= ST_FIN;
                        end else begin
                            r_out_value <= '0;
                            r_out_empty <= (r_func == FUNC_DEQ);
                            r_out_full  <= (r_func == FUNC_ENQ) && is_full;
                            r_out_queue <= PICK_W'(q);
                            r_state     <= ST_IDLE;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out_value <= ring_rdata.value;
                        r_out_empty <= 1'b0;
                        r_out_full  <= 1'b0;
                        r_out_queue <= PICK_W'(r_q);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.out_value    = r_out_value;
    assign o_out.was_empty    = r_out_empty;
    assign o_out.was_full     = r_out_full;
    assign o_out.chosen_queue = r_out_queue;

endmodule
